[rtl/twpt_pkg.sv]
package twpt_pkg;

  localparam int MAX_NODES_DEF     = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Entries of the letter queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] letter;
    logic                letter_ok;
    logic                last;
  } item_t;

endpackage

[rtl/twpt_ram.sv]
module twpt_ram import twpt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/twpt_front.sv]
module twpt_front import twpt_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic [CMD_W-1:0]    s_tuser,
  input  logic                s_tlast,
  input  logic                clearing,
  input  logic                q_full,
  output logic                push,
  output item_t               push_item
);

  logic [LETTER_W-1:0] letter;

  assign letter   = s_tdata[LETTER_W-1:0];
  assign s_tready = !q_full && !clearing;

  // Drop the unused command code here; it never reaches the walker.
  assign push = s_tvalid && s_tready && (s_tuser != CMD_NONE);

  always_comb begin
    push_item.cmd       = s_tuser;
    push_item.letter    = letter;
    push_item.letter_ok = (32'(letter) < ALPHABET_SIZE);
    push_item.last      = s_tlast;
  end

endmodule

[rtl/twpt_queue.sv]
module twpt_queue import twpt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  q_valid,
  output logic  q_full,
  output item_t q_item
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  item_t       slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;

  assign q_valid = (count != '0);
  assign q_full  = (count == (QW+1)'(QUEUE_DEPTH));
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/twpt_back.sv]
module twpt_back import twpt_pkg::*; #(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       pop,
  output logic       clearing,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_MARK  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [LINK_AW-1:0] clr_cnt;
  item_t              cur;
  logic [LINK_AW-1:0] slot;
  logic [LINK_AW-1:0] slot_next;
  logic [NODE_W-1:0]  cursor;
  logic [NODE_W-1:0]  cursor_next;
  logic               broken;
  logic               broken_next;
  logic               exhausted;
  logic               exhausted_next;
  logic [NODE_W:0]    next_free;
  logic               alloc;
  logic               found;
  logic               full;
  logic               res_load;
  logic               res_found;
  logic               res_full;
  logic               word_done;

  logic               link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [NODE_W-1:0]  link_wdata;
  logic [NODE_W-1:0]  link_rdata;
  logic               mark_we;
  logic [NODE_W-1:0]  mark_waddr;
  logic               mark_wdata;
  logic               mark_rdata;

  assign clearing  = (state == ST_CLEAR);
  assign slot_next = LINK_AW'(cursor) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(q_item.letter);
  assign m_tdata   = {6'd0, res_full, res_found};

  // Take a last letter only once the result register is free or draining.
  assign pop = (state == ST_IDLE) && q_valid && (!q_item.last || !m_tvalid || m_tready);

  twpt_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (slot_next),
    .rdata (link_rdata)
  );

  twpt_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (cursor_next),
    .rdata (mark_rdata)
  );

  // Walk one letter against the link just read.
  always_comb begin
    cursor_next    = cursor;
    broken_next    = broken;
    exhausted_next = exhausted;
    alloc          = 1'b0;
    if (!broken) begin
      if (!cur.letter_ok) begin
        broken_next = 1'b1;
      end else if (link_rdata == '0) begin
        if (cur.cmd != CMD_INSERT) begin
          broken_next = 1'b1;
        end else if (next_free == (NODE_W+1)'(MAX_NODES)) begin
          broken_next    = 1'b1;
          exhausted_next = 1'b1;
        end else begin
          alloc       = 1'b1;
          cursor_next = next_free[NODE_W-1:0];
        end
      end else begin
        cursor_next = link_rdata;
      end
    end
  end

  always_comb begin
    state_next = state;
    found      = 1'b0;
    full       = 1'b0;
    res_load   = 1'b0;
    word_done  = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = next_free[NODE_W-1:0];
    mark_we    = 1'b0;
    mark_waddr = cursor_next;
    mark_wdata = 1'b1;
    case (state)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_cnt;
        link_wdata = '0;
        mark_we    = (clr_cnt < LINK_AW'(MAX_NODES));
        mark_waddr = clr_cnt[NODE_W-1:0];
        mark_wdata = 1'b0;
        if (clr_cnt == LINK_AW'(LINK_DEPTH-1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        link_we    = alloc;
        state_next = ST_IDLE;
        if (cur.last) begin
          case (cur.cmd)
            CMD_INSERT: begin
              mark_we   = !broken_next;
              found     = !broken_next;
              full      = exhausted_next;
              res_load  = 1'b1;
              word_done = 1'b1;
            end
            CMD_SEARCH: begin
              if (broken_next) begin
                res_load  = 1'b1;
                word_done = 1'b1;
              end else begin
                state_next = ST_MARK;
              end
            end
            default: begin
              found     = !broken_next;
              res_load  = 1'b1;
              word_done = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        found      = mark_rdata;
        res_load   = 1'b1;
        word_done  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_item;
      slot <= slot_next;
    end
    if (res_load) begin
      res_found <= found;
      res_full  <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cursor    <= '0;
      broken    <= 1'b0;
      exhausted <= 1'b0;
      next_free <= (NODE_W+1)'(1);
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_LOOK) begin
        cursor    <= cursor_next;
        broken    <= broken_next;
        exhausted <= exhausted_next;
        if (alloc) begin
          next_free <= next_free + 1'b1;
        end
      end
      // Return to the root once the word has its result.
      if (word_done) begin
        cursor    <= '0;
        broken    <= 1'b0;
        exhausted <= 1'b0;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!$past(m_tvalid) || $past(m_tready) || !m_tvalid))
    else $error("result register overwritten while held");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("table_full reported together with found");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NODE_W+1)'(MAX_NODES))
    else $error("node pool pointer beyond pool");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("letter taken during clearing pass");

  a_alloc_only_look: assert property (@(posedge clk) disable iff (rst)
    (next_free != $past(next_free)) |-> ($past(state) == ST_LOOK && $past(alloc)))
    else $error("node allocated outside a lookup");

endmodule

[rtl/trie_word_prefix_table.sv]
// Letters enter through a 4-entry queue at one per cycle while it has room; the walker drains it.
// Walker: one letter at a time, a link read, then a link/mark write; the last
// letter of a search also reads the word-end mark.
// The result is registered in the last letter's link write step, or in the mark read step for a search.
// After rst, a clearing pass zeroes the link and mark memories, one slot a cycle,
// over all MAX_NODES*ALPHABET_SIZE link slots (26624 by default); s_tready stays low then.
module trie_word_prefix_table import twpt_pkg::*; #(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [4:0] letter, [7:5] zero
  input  logic [CMD_W-1:0] s_tuser,   // [1:0] cmd
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata    // [0] found, [1] table_full, [7:2] zero
);

  logic  clearing;
  logic  q_full;
  logic  q_valid;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t q_item;

  twpt_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  twpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  twpt_back #(
    .MAX_NODES     (MAX_NODES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[bench/trie_word_prefix_table_tb.sv]
import twpt_pkg::*;

typedef struct packed {
  logic found;
  logic table_full;
} verdict_t;

typedef struct packed {
  logic [3:0]      len;
  logic [7:0][4:0] letters;
} spelling_t;

class prefix_trie_check;
  localparam int NODES = MAX_NODES_DEF;
  localparam int ALPHA = ALPHABET_SIZE_DEF;

  logic [9:0]  link [NODES*ALPHA];
  bit          word_end [NODES];
  int unsigned cursor;
  bit          broken;
  bit          exhausted;
  int unsigned next_free;
  verdict_t    due_verdicts[$];

  function new();
    foreach (link[i]) link[i] = '0;
    foreach (word_end[i]) word_end[i] = 1'b0;
    cursor    = 0;
    broken    = 1'b0;
    exhausted = 1'b0;
    next_free = 1;
  endfunction

  // Advance the shared cursor by one letter; queue a verdict on the last one.
  function void take_letter(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter, logic last);
    int unsigned slot;
    int unsigned child;
    verdict_t    v;
    if (cmd == CMD_NONE) return;
    if (!broken) begin
      if (letter >= ALPHA) begin
        broken = 1'b1;
      end else begin
        slot  = cursor * ALPHA + letter;
        child = link[slot];
        if (child == 0) begin
          if (cmd != CMD_INSERT) begin
            broken = 1'b1;
          end else if (next_free >= NODES) begin
            exhausted = 1'b1;
            broken    = 1'b1;
          end else begin
            child = next_free;
            next_free++;
            link[slot] = child[9:0];
          end
        end
        if (!broken) cursor = child;
      end
    end
    if (!last) return;
    v = '0;
    case (cmd)
      CMD_INSERT: begin
        if (!broken) begin
          word_end[cursor] = 1'b1;
          v.found = 1'b1;
        end
        v.table_full = exhausted;
      end
      CMD_SEARCH: v.found = !broken && word_end[cursor];
      default:    v.found = !broken;
    endcase
    due_verdicts.push_back(v);
    cursor    = 0;
    broken    = 1'b0;
    exhausted = 1'b0;
  endfunction

  // Return an empty string when the result matches the oldest verdict.
  function string check_verdict(logic [7:0] tdata);
    verdict_t v;
    string    why;
    if (due_verdicts.size() == 0) return $sformatf("unexpected result %h", tdata);
    v   = due_verdicts.pop_front();
    why = "";
    if (tdata[0] !== v.found)
      why = {why, $sformatf(" found %b expected %b", tdata[0], v.found)};
    if (tdata[1] !== v.table_full)
      why = {why, $sformatf(" table_full %b expected %b", tdata[1], v.table_full)};
    if (tdata[7:2] !== 6'd0)
      why = {why, $sformatf(" padding %b not zero", tdata[7:2])};
    return why;
  endfunction

  function int pending();
    return due_verdicts.size();
  endfunction

  function bit pool_spent();
    return next_free >= NODES;
  endfunction
endclass

module trie_word_prefix_table_tb;
  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic [7:0]       s_tdata  = 8'd0;
  logic [CMD_W-1:0] s_tuser  = CMD_NONE;
  logic             s_tlast  = 1'b0;
  logic             m_tready = 1'b0;
  wire              s_tready;
  wire              m_tvalid;
  wire  [7:0]       m_tdata;

  prefix_trie_check trie_chk;
  spelling_t        dict[$];
  int               src_idle_pct  = 0;
  int               snk_stall_pct = 0;
  int               errors        = 0;
  int               letters_sent  = 0;

  trie_word_prefix_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("mismatch at %0t:%s", $time, msg);
  endtask

  task send_letter(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter,
                   input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, letter};
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    trie_chk.take_letter(cmd, letter, last);
    if (cmd != CMD_NONE) letters_sent++;
  endtask

  task send_word(input logic [CMD_W-1:0] cmd, input spelling_t w);
    for (int i = 0; i < w.len; i++) send_letter(cmd, w.letters[i], i == w.len - 1);
  endtask

  function spelling_t random_spelling(int top_letter);
    spelling_t w;
    w     = '0;
    w.len = 4'($urandom_range(1, 6));
    for (int i = 0; i < 8; i++) w.letters[i] = 5'($urandom_range(0, top_letter));
    return w;
  endfunction

  task run_random(input int n);
    int               target;
    int               pick;
    int               len;
    logic [CMD_W-1:0] cmd;
    spelling_t        w;
    target = letters_sent + n;
    while (letters_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_letter(CMD_NONE, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        // mixed codes, stray letters past z, ignored items in the middle
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) send_letter(CMD_NONE, 5'($urandom_range(0, 31)), 1'b1);
          send_letter(2'($urandom_range(int'(CMD_INSERT), int'(CMD_PREFIX))),
                      5'($urandom_range(0, ($urandom_range(3) == 0) ? 31 : 3)), i == len - 1);
        end
      end else begin
        cmd = ($urandom_range(99) < 40) ? CMD_INSERT
              : 2'($urandom_range(int'(CMD_SEARCH), int'(CMD_PREFIX)));
        if (dict.size() > 0 && $urandom_range(1) == 1) begin
          w = dict[$urandom_range(0, dict.size() - 1)];
          if (cmd != CMD_INSERT && w.len > 1 && $urandom_range(9) < 3)
            w.len = 4'($urandom_range(1, w.len - 1));
        end else begin
          w = random_spelling(($urandom_range(3) == 0) ? 25 : 3);
        end
        send_word(cmd, w);
        if (cmd == CMD_INSERT && dict.size() < 64) dict.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    string why;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      why = trie_chk.check_verdict(m_tdata);
      if (why != "") report_mismatch(why);
    end
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    trie_chk = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty tree, single letters, the last letter, stray letters, ignored code
    send_letter(CMD_SEARCH, 5'd25, 1'b1);
    send_letter(CMD_INSERT, 5'd0,  1'b1);
    send_letter(CMD_SEARCH, 5'd0,  1'b1);
    send_letter(CMD_PREFIX, 5'd0,  1'b1);
    send_letter(CMD_INSERT, 5'd25, 1'b0);
    send_letter(CMD_INSERT, 5'd25, 1'b1);
    send_letter(CMD_SEARCH, 5'd25, 1'b1);
    send_letter(CMD_PREFIX, 5'd25, 1'b1);
    send_letter(CMD_SEARCH, 5'd31, 1'b1);
    send_letter(CMD_INSERT, 5'd0,  1'b0);
    send_letter(CMD_INSERT, 5'd26, 1'b1);
    send_letter(CMD_PREFIX, 5'd25, 1'b0);
    send_letter(CMD_PREFIX, 5'd31, 1'b1);
    send_letter(CMD_NONE,   5'd31, 1'b1);
    send_letter(CMD_NONE,   5'd0,  1'b0);
    send_letter(CMD_INSERT, 5'd1,  1'b0);
    send_letter(CMD_INSERT, 5'd2,  1'b0);
    send_letter(CMD_PREFIX, 5'd3,  1'b1);
    send_letter(CMD_PREFIX, 5'd1,  1'b0);
    send_letter(CMD_PREFIX, 5'd2,  1'b1);
    send_letter(CMD_SEARCH, 5'd1,  1'b0);
    send_letter(CMD_SEARCH, 5'd2,  1'b1);

    src_idle_pct = 0;  snk_stall_pct = 0;  run_random(113);
    src_idle_pct = 64; snk_stall_pct = 0;  run_random(113);
    src_idle_pct = 0;  snk_stall_pct = 64; run_random(113);
    src_idle_pct = 27; snk_stall_pct = 27; run_random(113);

    // drain the node pool with long fresh words, then keep going on a full pool
    while (!trie_chk.pool_spent())
      for (int i = 0; i < 40; i++) send_letter(CMD_INSERT, 5'($urandom_range(0, 25)), i == 39);
    src_idle_pct = 0; snk_stall_pct = 0;
    run_random(60);

    s_tvalid <= 1'b0;
    while (trie_chk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("trie_word_prefix_table regression: pass");
    end else begin
      $display("trie_word_prefix_table regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("trie_word_prefix_table regression: fail");
    $finish;
  end
endmodule

[sim.f]
rtl/twpt_pkg.sv
rtl/twpt_ram.sv
rtl/twpt_front.sv
rtl/twpt_queue.sv
rtl/twpt_back.sv
rtl/trie_word_prefix_table.sv
bench/trie_word_prefix_table_tb.sv
